// ===== hdl/rtcde_pkg.sv =====
// shared types, constants and helpers for the rtc date to epoch seconds unit
`default_nettype none

package rtcde_pkg;

  // raw field positions in the low time word
  localparam int unsigned SEC_LSB   = 4;
  localparam int unsigned MIN_LSB   = 10;
  localparam int unsigned HOUR_LSB  = 16;
  localparam int unsigned DAY_LSB   = 21;
  localparam int unsigned MONTH_LSB = 26;

  // calendar constants
  localparam logic [10:0] YEAR_BASE    = 11'd1900;
  localparam logic [10:0] YEAR_MIN     = 11'd1970;
  localparam logic [8:0]  ERA_YEARS    = 9'd400;
  localparam logic [17:0] ERA_DAYS     = 18'd146097;
  localparam logic [19:0] EPOCH_OFFSET = 20'd719468;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [11:0] SECS_PER_HR  = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;
  localparam logic [8:0]  DAYS_PER_YR  = 9'd365;

  // widths of the datapath
  localparam int unsigned YEAR_W  = 33;
  localparam int unsigned QIN_W   = YEAR_W - 4;
  localparam int unsigned ERA_W   = 25;
  localparam int unsigned YOE_W   = 9;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned DOE_W   = 18;
  localparam int unsigned TOD_W   = 17;
  localparam int unsigned EDAY_W  = ERA_W + 18;
  localparam int unsigned DAYS_W  = 42;
  localparam int unsigned HALF_W  = DAYS_W / 2;
  localparam int unsigned PART_W  = HALF_W + 17;
  localparam int unsigned EPOCH_W = 57;

  // y / 400 == (y >> 4) / 25, exact reciprocal for a 29-bit dividend
  localparam int unsigned DIV25_SHIFT = QIN_W + 5;
  localparam logic [29:0] DIV25_MUL   = 30'd687194768;
  localparam int unsigned PROD_W      = QIN_W + 30;

  // control that travels down the pipeline
  typedef struct packed {
    logic vld;
    logic ok;
  } ctl_t;

  // days from march 1 to the first of the month, march-based month index
  function automatic logic [8:0] month_start_doy(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // whole centuries in a year of era, 0 to 3
  function automatic logic [1:0] centuries(input logic [YOE_W-1:0] yoe);
    logic [1:0] c;
    if (yoe >= 9'd300) begin
      c = 2'd3;
    end else if (yoe >= 9'd200) begin
      c = 2'd2;
    end else if (yoe >= 9'd100) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rtc_date_to_epoch_seconds_unit.sv =====
// rtc time words to seconds since 1970-01-01, six stage pipeline
// one transaction accepted every cycle; busy never rises, the receiver cannot stall
// the result strobe is registered after the unpack, reciprocal divide, era multiply, epoch
//   shift, split day multiply and combine stages
// reset: synchronous active low, clears the stage control bits, strobe and valid flag only
`default_nettype none

module rtc_date_to_epoch_seconds_unit
  import rtcde_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [31:0]        in_toy_low_word,
  input  wire logic [31:0]        in_toy_high_word,
  output logic                    out_strobe,
  output logic      [EPOCH_W-1:0] out_epoch_seconds,
  output logic                    out_time_valid
);

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: unpack, range check, shifted year, day of year, time of day
  logic [5:0]        f_sec;
  logic [5:0]        f_min;
  logic [4:0]        f_hour;
  logic [4:0]        f_day;
  logic [5:0]        f_month;
  logic [YEAR_W-1:0] f_year;
  logic              f_early;
  logic [3:0]        f_mp;
  ctl_t              s1_ctl_nxt;
  logic [YEAR_W-1:0] s1_year_nxt;
  logic [DOY_W-1:0]  s1_doy_nxt;
  logic [TOD_W-1:0]  s1_tod_nxt;

  assign f_sec   = in_toy_low_word[SEC_LSB +: 6];
  assign f_min   = in_toy_low_word[MIN_LSB +: 6];
  assign f_hour  = in_toy_low_word[HOUR_LSB +: 5];
  assign f_day   = in_toy_low_word[DAY_LSB +: 5];
  assign f_month = in_toy_low_word[MONTH_LSB +: 6];
  assign f_year  = YEAR_W'(in_toy_high_word) + YEAR_W'(YEAR_BASE);
  assign f_early = (f_month <= 6'd2);
  assign f_mp    = f_early ? 4'(f_month + 6'd9) : 4'(f_month - 6'd3);

  assign s1_ctl_nxt.vld = accept;
  assign s1_ctl_nxt.ok  = (f_year >= YEAR_W'(YEAR_MIN))
                       && (f_month >= 6'd1) && (f_month <= 6'd12)
                       && (f_day >= 5'd1) && (f_hour <= 5'd23)
                       && (f_min <= 6'd59) && (f_sec <= 6'd59);
  assign s1_year_nxt    = f_year - YEAR_W'(f_early);
  assign s1_doy_nxt     = month_start_doy(f_mp) + DOY_W'(f_day) - 9'd1;
  assign s1_tod_nxt     = TOD_W'(f_hour) * TOD_W'(SECS_PER_HR)
                        + TOD_W'(f_min) * TOD_W'(SECS_PER_MIN)
                        + TOD_W'(f_sec);

  ctl_t              s1_ctl_r;
  logic [YEAR_W-1:0] s1_year_r;
  logic [DOY_W-1:0]  s1_doy_r;
  logic [TOD_W-1:0]  s1_tod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
    end
    s1_year_r <= s1_year_nxt;
    s1_doy_r  <= s1_doy_nxt;
    s1_tod_r  <= s1_tod_nxt;
  end

  // stages 2 to 4: days since epoch
  ctl_t              dc_ctl;
  logic [DAYS_W-1:0] dc_days;
  logic [TOD_W-1:0]  dc_tod;

  rtcde_day_count u_day_count (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (s1_ctl_r),
    .year_i (s1_year_r),
    .doy_i  (s1_doy_r),
    .tod_i  (s1_tod_r),
    .ctl_o  (dc_ctl),
    .days_o (dc_days),
    .tod_o  (dc_tod)
  );

  // stage 5: days times seconds per day, in two halves
  ctl_t              s5_ctl_r;
  logic [TOD_W-1:0]  s5_tod_r;
  logic [PART_W-1:0] s5_lo_r;
  logic [PART_W-1:0] s5_hi_r;
  logic [PART_W-1:0] s5_lo_nxt;
  logic [PART_W-1:0] s5_hi_nxt;

  assign s5_lo_nxt = PART_W'(dc_days[HALF_W-1:0]) * PART_W'(SECS_PER_DAY);
  assign s5_hi_nxt = PART_W'(dc_days[DAYS_W-1:HALF_W]) * PART_W'(SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_ctl_r <= '0;
    end else begin
      s5_ctl_r <= dc_ctl;
    end
    s5_tod_r <= dc_tod;
    s5_lo_r  <= s5_lo_nxt;
    s5_hi_r  <= s5_hi_nxt;
  end

  // stage 6: combine halves and time of day, zero when out of range
  localparam int unsigned SUM_W = PART_W + HALF_W + 1;

  logic [SUM_W-1:0]   s6_sum;
  logic [EPOCH_W-1:0] s6_epoch_nxt;
  logic               strobe_r;
  logic               time_valid_r;
  logic [EPOCH_W-1:0] epoch_r;

  assign s6_sum       = (SUM_W'(s5_hi_r) << HALF_W) + SUM_W'(s5_lo_r) + SUM_W'(s5_tod_r);
  assign s6_epoch_nxt = s5_ctl_r.ok ? s6_sum[EPOCH_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r     <= 1'b0;
      time_valid_r <= 1'b0;
    end else begin
      strobe_r     <= s5_ctl_r.vld;
      time_valid_r <= s5_ctl_r.vld && s5_ctl_r.ok;
    end
    epoch_r <= s6_epoch_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_time_valid    = time_valid_r;
  assign out_epoch_seconds = epoch_r;

  // every accepted transaction yields a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_strobe)
    else $error("result strobe missing after accepted transaction");

  // an invalid result carries zero seconds
  a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_time_valid) |-> (out_epoch_seconds == '0))
    else $error("invalid time with nonzero seconds");

  // valid flag only rides with the strobe
  a_valid_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_time_valid |-> out_strobe)
    else $error("time valid without result strobe");

endmodule

`default_nettype wire

// ===== hdl/rtcde_day_count.sv =====
// three stage pipeline from shifted year and day of year to days since epoch
`default_nettype none

module rtcde_day_count
  import rtcde_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctl_t              ctl_i,
  input  wire logic [YEAR_W-1:0] year_i,
  input  wire logic [DOY_W-1:0]  doy_i,
  input  wire logic [TOD_W-1:0]  tod_i,
  output ctl_t                   ctl_o,
  output logic      [DAYS_W-1:0] days_o,
  output logic      [TOD_W-1:0]  tod_o
);

  // stage a: era by reciprocal multiply
  ctl_t              a_ctl_r;
  logic [YEAR_W-1:0] a_year_r;
  logic [DOY_W-1:0]  a_doy_r;
  logic [TOD_W-1:0]  a_tod_r;
  logic [ERA_W-1:0]  a_era_r;
  logic [PROD_W-1:0] a_prod;
  logic [ERA_W-1:0]  a_era_nxt;

  assign a_prod    = PROD_W'(year_i[YEAR_W-1:4]) * PROD_W'(DIV25_MUL);
  assign a_era_nxt = a_prod[DIV25_SHIFT +: ERA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
    end else begin
      a_ctl_r <= ctl_i;
    end
    a_year_r <= year_i;
    a_doy_r  <= doy_i;
    a_tod_r  <= tod_i;
    a_era_r  <= a_era_nxt;
  end

  // stage b: day of era and era days
  ctl_t              b_ctl_r;
  logic [TOD_W-1:0]  b_tod_r;
  logic [DOE_W-1:0]  b_doe_r;
  logic [EDAY_W-1:0] b_eday_r;
  logic [YEAR_W-1:0] b_era_years;
  logic [YEAR_W-1:0] b_yoe_full;
  logic [YOE_W-1:0]  b_yoe;
  logic [DOE_W-1:0]  b_doe_nxt;
  logic [EDAY_W-1:0] b_eday_nxt;

  assign b_era_years = YEAR_W'(a_era_r) * YEAR_W'(ERA_YEARS);
  assign b_yoe_full  = a_year_r - b_era_years;
  assign b_yoe       = b_yoe_full[YOE_W-1:0];
  assign b_doe_nxt   = DOE_W'(b_yoe) * DOE_W'(DAYS_PER_YR)
                     + DOE_W'(b_yoe[YOE_W-1:2])
                     - DOE_W'(centuries(b_yoe))
                     + DOE_W'(a_doy_r);
  assign b_eday_nxt  = EDAY_W'(a_era_r) * EDAY_W'(ERA_DAYS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
    end else begin
      b_ctl_r <= a_ctl_r;
    end
    b_tod_r  <= a_tod_r;
    b_doe_r  <= b_doe_nxt;
    b_eday_r <= b_eday_nxt;
  end

  // stage c: total days, shifted to the 1970 epoch
  ctl_t              c_ctl_r;
  logic [TOD_W-1:0]  c_tod_r;
  logic [DAYS_W-1:0] c_days_r;
  logic [EDAY_W-1:0] c_days_full;

  assign c_days_full = b_eday_r + EDAY_W'(b_doe_r) - EDAY_W'(EPOCH_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r <= '0;
    end else begin
      c_ctl_r <= b_ctl_r;
    end
    c_tod_r  <= b_tod_r;
    c_days_r <= c_days_full[DAYS_W-1:0];
  end

  assign ctl_o  = c_ctl_r;
  assign days_o = c_days_r;
  assign tod_o  = c_tod_r;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the rtc date to epoch seconds unit: random and directed time words vs a predictor
`timescale 1ns / 1ps

module tb;
  import rtcde_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int IDLE_PCT     = 26;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 2000;

  // one raw register pair
  typedef struct {
    logic [31:0] lo;
    logic [31:0] hi;
  } toy_words_t;

  // one converted time
  typedef struct {
    logic [EPOCH_W-1:0] epoch;
    logic               valid;
  } epoch_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [31:0]        in_toy_low_word;
  logic [31:0]        in_toy_high_word;
  logic               out_strobe;
  logic [EPOCH_W-1:0] out_epoch_seconds;
  logic               out_time_valid;

  toy_words_t    pending_words[$];
  epoch_result_t expected_times[$];
  toy_words_t    cur_words;
  logic          item_taken;
  int            sent_count;
  int            errors;
  int            stall_cycles;

  rtc_date_to_epoch_seconds_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_toy_low_word   (in_toy_low_word),
    .in_toy_high_word  (in_toy_high_word),
    .out_strobe        (out_strobe),
    .out_epoch_seconds (out_epoch_seconds),
    .out_time_valid    (out_time_valid)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // unix seconds from the raw words, march-based day count
  function automatic epoch_result_t civil_to_epoch(input logic [31:0] lo,
                                                   input logic [31:0] hi);
    bit [63:0] sec, minute, hour, day, month, year;
    bit [63:0] y, era, yoe, mp, doy, doe, days;
    epoch_result_t r;
    sec    = 64'(lo[9:4]);
    minute = 64'(lo[15:10]);
    hour   = 64'(lo[20:16]);
    day    = 64'(lo[25:21]);
    month  = 64'(lo[31:26]);
    year   = 64'd1900 + 64'(hi);
    r.epoch = '0;
    r.valid = 1'b0;
    if (year >= 64'd1970 && month >= 1 && month <= 12 && day >= 1 && day <= 31 &&
        hour <= 23 && minute <= 59 && sec <= 59) begin
      y    = year - ((month <= 2) ? 64'd1 : 64'd0);
      era  = y / 400;
      yoe  = y - era * 400;
      mp   = (month > 2) ? month - 3 : month + 9;
      doy  = (153 * mp + 2) / 5 + day - 1;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468;
      r.epoch = EPOCH_W'(days * 86400 + hour * 3600 + minute * 60 + sec);
      r.valid = 1'b1;
    end
    return r;
  endfunction

  // low word from its fields, random filler in bits 3:0
  function automatic logic [31:0] pack_low(input int sec, input int minute, input int hour,
                                           input int day, input int month);
    logic [31:0] w;
    w        = 32'($urandom_range(0, 15));
    w[9:4]   = 6'(sec);
    w[15:10] = 6'(minute);
    w[20:16] = 5'(hour);
    w[25:21] = 5'(day);
    w[31:26] = 6'(month);
    return w;
  endfunction

  task automatic queue_words(input logic [31:0] lo, input logic [31:0] hi);
    toy_words_t t;
    t.lo = lo;
    t.hi = hi;
    pending_words.push_back(t);
  endtask

  // driver: present the next transaction at the falling edge, hold it until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (pending_words.size() != 0 &&
          ((sent_count >= 200 && sent_count < 350) || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cur_words = pending_words.pop_front();
        in_toy_low_word  <= cur_words.lo;
        in_toy_high_word <= cur_words.hi;
        start            <= 1'b1;
        sent_count++;
      end else begin
        in_toy_low_word  <= $urandom;
        in_toy_high_word <= $urandom;
        start            <= 1'b0;
      end
    end
  end

  // accepted transaction: predict its result
  always @(posedge clk) begin
    item_taken = rst_n && start && !busy;
    if (item_taken) begin
      expected_times.push_back(civil_to_epoch(in_toy_low_word, in_toy_high_word));
    end
  end

  // monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    epoch_result_t exp_r;
    if (rst_n && out_strobe) begin
      if (expected_times.size() == 0) begin
        $error("unexpected result: epoch_seconds %0d time_valid %0b",
               out_epoch_seconds, out_time_valid);
        errors++;
      end else begin
        exp_r = expected_times.pop_front();
        if (out_epoch_seconds !== exp_r.epoch) begin
          $error("epoch_seconds: expected %0d, got %0d", exp_r.epoch, out_epoch_seconds);
          errors++;
        end
        if (out_time_valid !== exp_r.valid) begin
          $error("time_valid: expected %0b, got %0b", exp_r.valid, out_time_valid);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction either way
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int sel;
    int kind;
    int sec, minute, hour, day, month;
    logic [31:0] hi;
    start            = 1'b0;
    in_toy_low_word  = '0;
    in_toy_high_word = '0;
    item_taken       = 1'b0;
    sent_count       = 0;
    errors           = 0;
    stall_cycles     = 0;

    // directed: epoch origin, year and field limits, month end rollover, leap rules
    queue_words(pack_low(0, 0, 0, 1, 1), 32'd70);
    queue_words(pack_low(59, 59, 23, 31, 12), 32'd69);
    queue_words(pack_low(59, 59, 23, 31, 12), 32'd0);
    queue_words(pack_low(59, 59, 23, 31, 12), 32'hFFFF_FFFF);
    queue_words(pack_low(0, 0, 0, 1, 1), 32'hFFFF_FFFF);
    queue_words(pack_low(30, 30, 12, 15, 0), 32'd100);
    queue_words(pack_low(30, 30, 12, 15, 13), 32'd100);
    queue_words(pack_low(30, 30, 12, 15, 63), 32'd100);
    queue_words(pack_low(30, 30, 12, 0, 6), 32'd100);
    queue_words(pack_low(30, 30, 24, 15, 6), 32'd100);
    queue_words(pack_low(30, 30, 31, 15, 6), 32'd100);
    queue_words(pack_low(30, 60, 12, 15, 6), 32'd100);
    queue_words(pack_low(30, 63, 12, 15, 6), 32'd100);
    queue_words(pack_low(60, 30, 12, 15, 6), 32'd100);
    queue_words(pack_low(63, 30, 12, 15, 6), 32'd100);
    queue_words(pack_low(0, 0, 0, 30, 2), 32'd123);
    queue_words(pack_low(0, 0, 0, 31, 2), 32'd100);
    queue_words(pack_low(0, 0, 0, 29, 2), 32'd200);
    queue_words(pack_low(0, 0, 0, 31, 4), 32'd101);
    queue_words(pack_low(0, 0, 0, 1, 3), 32'd500);
    queue_words(pack_low(0, 0, 0, 28, 2), 32'd138);
    queue_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_words(32'h0000_0000, 32'h0000_0000);
    queue_words(pack_low(7, 8, 9, 10, 11), 32'h7FFF_FFFF);

    // random: mostly well-formed times, some with one field broken, some raw noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sec    = $urandom_range(0, 59);
      minute = $urandom_range(0, 59);
      hour   = $urandom_range(0, 23);
      day    = $urandom_range(1, 31);
      month  = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       hi = $urandom_range(70, 200);
        1:       hi = $urandom_range(70, 2100);
        2:       hi = $urandom_range(70, 32'hFFFF_FFFF);
        default: hi = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        queue_words(pack_low(sec, minute, hour, day, month), hi);
      end else if (sel < 85) begin
        kind = $urandom_range(0, 5);
        case (kind)
          0: hi = $urandom_range(0, 69);
          1: month = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 63);
          2: day = 0;
          3: hour = $urandom_range(24, 31);
          4: minute = $urandom_range(60, 63);
          default: sec = $urandom_range(60, 63);
        endcase
        queue_words(pack_low(sec, minute, hour, day, month), hi);
      end else begin
        queue_words($urandom, $urandom);
      end
    end

    wait (pending_words.size() == 0 && !start);
    wait (expected_times.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== rtc_date_to_epoch_seconds_unit.f =====
hdl/rtcde_pkg.sv
hdl/rtcde_day_count.sv
hdl/rtc_date_to_epoch_seconds_unit.sv
dv/tb.sv
